// File: rtl/clsm_pkg.sv
// Package for the column line scan mask: field widths, column state and
// pipeline stage types, and the packing of stream data.
// Depends on nothing; every other file of the block uses it.
package clsm_pkg;

  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int PIX_W    = 8;
  localparam int THR_W    = 10;
  localparam int COLS     = 1024;
  localparam int ADDR_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CLEAR_LAST = COLS - 1;

  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 48;
  localparam int APB_AW   = 3;

  localparam logic [0:0] REG_GAP_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_EDGE_LEVEL    = 1'b1;

  localparam logic [THR_W-1:0] GAP_THRESHOLD_RESET = THR_W'(10);
  localparam logic [PIX_W-1:0] EDGE_LEVEL_RESET    = PIX_W'(255);

  typedef struct packed {
    logic             top_found;
    logic [ROW_W-1:0] top_row;
    logic             bot_found;
    logic [ROW_W-1:0] bot_row;
  } col_state_t;

  localparam int STATE_W = $bits(col_state_t);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             in_range;
    logic             frame_start;
    logic             is_edge;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] col;
    logic             in_range;
    col_state_t       state;
  } result_t;

  function automatic logic [M_DATA_W-1:0] pack_result(input result_t res);
    pack_result = {2'b00, res.state.top_row, res.state.top_found,
                   res.state.bot_row, res.state.bot_found,
                   res.blue, res.green, res.red};
  endfunction

endpackage

// File: rtl/clsm_col_ram.sv
// Column state memory of the column line scan mask: one write port and one
// read port with registered read data. Depends on clsm_pkg.
module clsm_col_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [clsm_pkg::ADDR_W-1:0]  waddr,
  input  clsm_pkg::col_state_t         wdata,
  input  logic [clsm_pkg::ADDR_W-1:0]  raddr,
  output clsm_pkg::col_state_t         rdata
);

  clsm_pkg::col_state_t mem [clsm_pkg::COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/clsm_cfg.sv
// APB register file of the column line scan mask: gap threshold and edge
// level. Depends on clsm_pkg.
module clsm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clsm_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [clsm_pkg::THR_W-1:0]    gap_threshold,
  output logic [clsm_pkg::PIX_W-1:0]    edge_level
);

  logic [0:0] reg_sel;
  logic       wr;

  assign reg_sel = paddr[2:2];
  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold <= clsm_pkg::GAP_THRESHOLD_RESET;
      edge_level    <= clsm_pkg::EDGE_LEVEL_RESET;
    end else if (wr) begin
      case (reg_sel)
        clsm_pkg::REG_GAP_THRESHOLD: gap_threshold <= pwdata[clsm_pkg::THR_W-1:0];
        clsm_pkg::REG_EDGE_LEVEL:    edge_level    <= pwdata[clsm_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      clsm_pkg::REG_GAP_THRESHOLD: prdata = {{(32-clsm_pkg::THR_W){1'b0}}, gap_threshold};
      clsm_pkg::REG_EDGE_LEVEL:    prdata = {{(32-clsm_pkg::PIX_W){1'b0}}, edge_level};
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: rtl/clsm_update.sv
// Column state update of the column line scan mask: applies frame start,
// forwarding, the edge rules and masking for one pixel. Depends on clsm_pkg.
module clsm_update (
  input  clsm_pkg::pix_t                pix,
  input  clsm_pkg::col_state_t          loaded,
  input  logic                          fwd_hit,
  input  clsm_pkg::col_state_t          fwd_state,
  input  logic [clsm_pkg::THR_W-1:0]    gap_threshold,
  output clsm_pkg::result_t             res
);

  clsm_pkg::col_state_t   cur;
  clsm_pkg::col_state_t   upd;
  logic [clsm_pkg::ROW_W-1:0] diff;

  always_comb begin
    if (pix.frame_start) begin
      cur = '0;
    end else if (fwd_hit) begin
      cur = fwd_state;
    end else begin
      cur = loaded;
    end

    diff = (pix.row >= cur.bot_row) ? (pix.row - cur.bot_row) : (cur.bot_row - pix.row);

    upd       = cur;
    res.red   = pix.red;
    res.green = pix.green;
    res.blue  = pix.blue;
    if (cur.top_found) begin
      res.red   = '0;
      res.green = '0;
      res.blue  = '0;
    end else if (pix.is_edge) begin
      if (!cur.bot_found) begin
        upd.bot_found = 1'b1;
        upd.bot_row   = pix.row;
      end else if (diff > gap_threshold) begin
        upd.top_found = 1'b1;
        upd.top_row   = pix.row;
      end else begin
        upd.bot_row = pix.row;
      end
    end

    if (!pix.in_range) begin
      upd       = '0;
      res.red   = pix.red;
      res.green = pix.green;
      res.blue  = pix.blue;
    end

    res.col      = pix.col;
    res.in_range = pix.in_range;
    res.state    = upd;
  end

endmodule

// File: rtl/column_line_scan_mask.sv
// Column line scan mask: per-column line bottom and top tracker that blacks
// out pixels above a found line top.
// Pixels enter on the s_ stream (tdata: row_index, col_index, edge_gray,
// red_in, green_in, blue_in from bit 0 up; tuser: frame_start) and leave on
// the m_ stream with the pixel, masked or not, and the column's bottom and
// top rows after that pixel. Registers gap_threshold (address 0) and
// edge_level (address 4) are written over the APB port; the user must do so
// only while the block is idle, and the block itself does not enforce it.
// One pixel is taken every cycle unless the pipeline is held or the memory
// is being cleared. A result passes through the column memory read, the state
// update and the output register. Back-to-back pixels of the same column
// are resolved by forwarding from the output register and the last write.
// After reset the column memory is cleared, one column a cycle, over all 1024
// columns; s_tready stays low during that pass and configuration writes are
// still taken. When the receiver holds m_tready low with a result waiting,
// the whole pipeline holds, and s_tready falls with it, so nothing is lost
// or repeated.
// Depends on clsm_pkg, clsm_cfg, clsm_col_ram and clsm_update.
module column_line_scan_mask (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index, col_index, edge_gray, red_in, green_in, blue_in, zero pad
  input  logic [clsm_pkg::S_DATA_W-1:0]   s_tdata,
  // frame_start
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // red_out, green_out, blue_out, bottom_found, bottom_row, top_found,
  // top_row, zero pad
  output logic [clsm_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clsm_pkg::APB_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [clsm_pkg::THR_W-1:0]  gap_threshold;
  logic [clsm_pkg::PIX_W-1:0]  edge_level;

  logic                        advance;
  logic                        in_xfer;
  clsm_pkg::pix_t              in_pix;

  logic                        clearing;
  logic [clsm_pkg::ADDR_W-1:0] clear_addr;

  logic                        s1_valid;
  clsm_pkg::pix_t              s1_pix;
  logic                        s2_valid;
  clsm_pkg::pix_t              s2_pix;
  clsm_pkg::col_state_t        s2_state;
  logic                        s3_valid;
  clsm_pkg::result_t           s3_res;

  logic                        rec_valid;
  logic [clsm_pkg::COL_W-1:0]  rec_col;
  clsm_pkg::col_state_t        rec_state;

  logic [clsm_pkg::ADDR_W-1:0] raddr;
  clsm_pkg::col_state_t        rdata;
  clsm_pkg::col_state_t        s1_state;
  logic                        ram_we;
  logic [clsm_pkg::ADDR_W-1:0] ram_waddr;
  clsm_pkg::col_state_t        ram_wdata;

  logic                        pipe_we;
  logic                        fwd_hit;
  clsm_pkg::result_t           s2_res;

  clsm_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .gap_threshold (gap_threshold),
    .edge_level    (edge_level)
  );

  assign advance  = !s3_valid || m_tready;
  assign s_tready = advance && !clearing;
  assign in_xfer  = s_tvalid && s_tready;

  always_comb begin
    in_pix.row         = s_tdata[9:0];
    in_pix.col         = s_tdata[19:10];
    in_pix.in_range    = (int'(s_tdata[19:10]) < clsm_pkg::COLS);
    in_pix.frame_start = s_tuser;
    in_pix.is_edge     = (s_tdata[27:20] == edge_level);
    in_pix.red         = s_tdata[35:28];
    in_pix.green       = s_tdata[43:36];
    in_pix.blue        = s_tdata[51:44];
  end

  assign raddr = advance ? in_pix.col[clsm_pkg::ADDR_W-1:0]
                         : s1_pix.col[clsm_pkg::ADDR_W-1:0];

  assign pipe_we   = advance && s2_valid && s2_pix.in_range;
  assign ram_we    = clearing || pipe_we;
  assign ram_waddr = clearing ? clear_addr : s2_pix.col[clsm_pkg::ADDR_W-1:0];
  assign ram_wdata = clearing ? '0 : s2_res.state;

  clsm_col_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign s1_state = (rec_valid && rec_col == s1_pix.col) ? rec_state : rdata;

  assign fwd_hit = s3_valid && s3_res.in_range && (s3_res.col == s2_pix.col);

  clsm_update u_update (
    .pix           (s2_pix),
    .loaded        (s2_state),
    .fwd_hit       (fwd_hit),
    .fwd_state     (s3_res.state),
    .gap_threshold (gap_threshold),
    .res           (s2_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == clsm_pkg::ADDR_W'(clsm_pkg::CLEAR_LAST)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      rec_valid <= pipe_we;
    end
    rec_col   <= s2_pix.col;
    rec_state <= s2_res.state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_xfer;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix         <= in_pix;
      s2_pix         <= s1_pix;
      s2_state       <= s1_state;
      s3_res         <= s2_res;
    end
  end

  assign m_tvalid = s3_valid;
  assign m_tdata  = clsm_pkg::pack_result(s3_res);

endmodule

// File: dv/testbench.sv
// Self-checking testbench for column_line_scan_mask: drives pixel frames and noise on the
// input stream, predicts each result from its own per-column line tracker and checks it.
// Depends on clsm_pkg and the RTL of column_line_scan_mask only.
module testbench;
  import clsm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [APB_AW-1:0] GAP_ADDR = APB_AW'(4 * REG_GAP_THRESHOLD);
  localparam logic [APB_AW-1:0] LVL_ADDR = APB_AW'(4 * REG_EDGE_LEVEL);

  typedef struct packed {
    logic [3:0]       pad;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] gray;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pixel_beat_t;

  typedef struct {
    pixel_beat_t beat;
    logic        frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [1:0]       pad;
    logic [ROW_W-1:0] top_row;
    logic             top_found;
    logic [ROW_W-1:0] bot_row;
    logic             bot_found;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } scan_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // Tracker copy used for prediction.
  logic                  bottom_valid [COLS];
  logic [ROW_W-1:0]      bottom_at [COLS];
  logic                  top_valid [COLS];
  logic [ROW_W-1:0]      top_at [COLS];
  logic [THR_W-1:0]      track_gap;
  logic [PIX_W-1:0]      track_level;

  pixel_item_t           pixel_backlog[$];
  scan_result_t          expected_pixels[$];
  bit                    s_fire;
  int unsigned           src_idle_pct;
  int unsigned           sink_stall_pct;
  int unsigned           fail_count;
  int unsigned           pixels_queued;
  int unsigned           results_seen;
  int unsigned           tops_found;
  int unsigned           pixels_blacked;
  int unsigned           frames_sent;
  int unsigned           cycle_count;
  logic [THR_W-1:0]      gen_gap;
  logic [PIX_W-1:0]      gen_level;

  column_line_scan_mask u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      note_failure($sformatf("%s expected %0d, got %0d (result %0d)", name, want, got,
                             results_seen));
    end
  endtask

  task automatic add_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                           input logic fs, input logic [PIX_W-1:0] gray,
                           input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                           input logic [PIX_W-1:0] b);
    pixel_item_t item;
    item.beat = '{pad: '0, blue: b, green: g, red: r, gray: gray, col: col, row: row};
    item.frame_start = fs;
    pixel_backlog.push_back(item);
    pixels_queued++;
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_backlog.size() != 0 || s_tvalid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Input driver: presents the next pixel once the current one has been taken.
  always @(negedge clk) begin
    pixel_item_t item;
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        item = pixel_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= item.beat;
        s_tuser  <= item.frame_start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    pixel_beat_t      pin;
    scan_result_t     want;
    scan_result_t     got;
    logic             bv;
    logic             tv;
    logic [ROW_W-1:0] br;
    logic [ROW_W-1:0] tr;
    logic [ROW_W-1:0] diff;
    s_fire = 1'b0;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          GAP_ADDR: track_gap = pwdata[THR_W-1:0];
          LVL_ADDR: track_level = pwdata[PIX_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        s_fire = 1'b1;
        pin = s_tdata;
        if (s_tuser) begin
          bottom_valid[pin.col] = 1'b0;
          bottom_at[pin.col]    = '0;
          top_valid[pin.col]    = 1'b0;
          top_at[pin.col]       = '0;
        end
        bv = bottom_valid[pin.col];
        br = bottom_at[pin.col];
        tv = top_valid[pin.col];
        tr = top_at[pin.col];
        want.pad   = '0;
        want.red   = pin.red;
        want.green = pin.green;
        want.blue  = pin.blue;
        if (tv) begin
          want.red   = '0;
          want.green = '0;
          want.blue  = '0;
          pixels_blacked++;
        end else if (pin.gray == track_level) begin
          if (!bv) begin
            bv = 1'b1;
            br = pin.row;
          end else begin
            diff = (pin.row >= br) ? pin.row - br : br - pin.row;
            if (diff > track_gap) begin
              tv = 1'b1;
              tr = pin.row;
              tops_found++;
            end else begin
              br = pin.row;
            end
          end
          bottom_valid[pin.col] = bv;
          bottom_at[pin.col]    = br;
          top_valid[pin.col]    = tv;
          top_at[pin.col]       = tr;
        end
        want.bot_found = bv;
        want.bot_row   = bv ? br : '0;
        want.top_found = tv;
        want.top_row   = tv ? tr : '0;
        expected_pixels.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("result 0x%h arrived with no pixel outstanding", m_tdata));
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.red, got.red);
          check_field("green_out", want.green, got.green);
          check_field("blue_out", want.blue, got.blue);
          check_field("bottom_found", want.bot_found, got.bot_found);
          check_field("bottom_row", want.bot_row, got.bot_row);
          check_field("top_found", want.top_found, got.top_found);
          check_field("top_row", want.top_row, got.top_row);
          check_field("tdata pad", 0, got.pad);
        end
        results_seen++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [COL_W-1:0] frame_cols [0:5];
    logic [ROW_W-1:0] row_now;
    logic [COL_W-1:0] base_col;
    int               ncols;
    int               nrows;
    int               stride;
    int               step_max;
    int unsigned      goal;
    logic             with_start;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    fail_count = 0;
    pixels_queued = 0;
    results_seen = 0;
    tops_found = 0;
    pixels_blacked = 0;
    frames_sent = 0;
    track_gap = GAP_THRESHOLD_RESET;
    track_level = EDGE_LEVEL_RESET;
    gen_gap = GAP_THRESHOLD_RESET;
    gen_level = EDGE_LEVEL_RESET;
    for (int i = 0; i < COLS; i++) begin
      bottom_valid[i] = 1'b0;
      bottom_at[i] = '0;
      top_valid[i] = 1'b0;
      top_at[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset register values.
    add_pixel(10'd0, 10'd0, 1'b1, 8'd255, 8'd255, 8'd0, 8'd255);
    add_pixel(10'd5, 10'd0, 1'b0, 8'd255, 8'd1, 8'd2, 8'd3);
    add_pixel(10'd15, 10'd0, 1'b0, 8'd255, 8'd4, 8'd5, 8'd6);
    add_pixel(10'd26, 10'd0, 1'b0, 8'd255, 8'd170, 8'd85, 8'd255);
    add_pixel(10'd27, 10'd0, 1'b0, 8'd0, 8'd255, 8'd255, 8'd255);
    add_pixel(10'd28, 10'd0, 1'b0, 8'd255, 8'd128, 8'd64, 8'd32);
    add_pixel(10'd1023, 10'd1023, 1'b1, 8'd255, 8'd0, 8'd0, 8'd0);
    add_pixel(10'd0, 10'd1023, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(10'd1, 10'd1023, 1'b0, 8'd254, 8'd255, 8'd255, 8'd255);
    add_pixel(10'd1023, 10'd0, 1'b1, 8'd254, 8'd85, 8'd170, 8'd85);
    add_pixel(10'd3, 10'd512, 1'b0, 8'd255, 8'd9, 8'd9, 8'd9);
    add_pixel(10'd2, 10'd512, 1'b1, 8'd255, 8'd10, 8'd11, 8'd12);
    add_pixel(10'd2, 10'd512, 1'b0, 8'd255, 8'd13, 8'd14, 8'd15);
    add_pixel(10'd100, 10'd300, 1'b1, 8'd255, 8'd1, 8'd1, 8'd1);
    add_pixel(10'd100, 10'd301, 1'b1, 8'd255, 8'd2, 8'd2, 8'd2);
    add_pixel(10'd111, 10'd300, 1'b0, 8'd255, 8'd3, 8'd3, 8'd3);
    add_pixel(10'd110, 10'd301, 1'b0, 8'd255, 8'd4, 8'd4, 8'd4);
    add_pixel(10'd112, 10'd300, 1'b0, 8'd0, 8'd5, 8'd5, 8'd5);
    add_pixel(10'd112, 10'd301, 1'b0, 8'd0, 8'd6, 8'd6, 8'd6);
    add_pixel(10'd89, 10'd301, 1'b0, 8'd255, 8'd7, 8'd7, 8'd7);

    for (int ph = 0; ph < 6; ph++) begin
      // The sender holds back here until every outstanding result is back.
      wait_drained();
      repeat (4) @(posedge clk);
      case (ph)
        0: begin gen_gap = 10'd3; gen_level = 8'd255; end
        1: begin gen_gap = 10'd0; gen_level = 8'd0; end
        2: begin gen_gap = 10'd1023; gen_level = 8'd200; end
        3: begin gen_gap = 10'($urandom_range(1, 40)); gen_level = 8'($urandom); end
        4: begin gen_gap = 10'd10; gen_level = 8'd255; end
        default: begin gen_gap = 10'($urandom_range(0, 60)); gen_level = 8'($urandom); end
      endcase
      write_reg(GAP_ADDR, 32'(gen_gap));
      write_reg(LVL_ADDR, 32'(gen_level));
      case (ph % 4)
        0: begin src_idle_pct = 0; sink_stall_pct = 0; end
        1: begin src_idle_pct = 55; sink_stall_pct = 0; end
        2: begin src_idle_pct = 0; sink_stall_pct = 55; end
        default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      goal = pixels_queued + 110;
      while (pixels_queued < goal) begin
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 4)) begin
            add_pixel(10'($urandom), 10'($urandom), ($urandom_range(7) == 0),
                      ($urandom_range(1) != 0) ? gen_level : 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
          end
        end else begin
          ncols = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 6);
          stride = ($urandom_range(1) != 0) ? 1 : $urandom_range(2, 300);
          base_col = 10'($urandom);
          for (int c = 0; c < ncols; c++) begin
            frame_cols[c] = base_col + 10'(c * stride);
          end
          nrows = $urandom_range(3, 10);
          step_max = (int'(gen_gap) * 2 + 2 > 1023) ? 1023 : int'(gen_gap) * 2 + 2;
          row_now = 10'($urandom);
          with_start = ($urandom_range(9) != 0);
          for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < ncols; c++) begin
              add_pixel(row_now, frame_cols[c], with_start && r == 0,
                        ($urandom_range(99) < 45) ? gen_level : 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom));
            end
            if ($urandom_range(9) == 0) begin
              row_now = row_now - 10'($urandom_range(1, step_max));
            end else begin
              row_now = row_now + 10'($urandom_range(1, step_max));
            end
          end
          frames_sent++;
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d pixels in %0d frames plus noise over six register settings.",
             pixels_queued, frames_sent);
    $display("Checked %0d results: %0d line tops set, %0d pixels blacked out.",
             results_seen, tops_found, pixels_blacked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
